// ----- rtl/core/acctilt_pkg.sv -----
// Shared constants, types and the arctangent table of the tilt-angle core.
`timescale 1ns / 1ps
package acctilt_pkg;

    localparam int SampleWidth = 16;
    localparam int FracBits    = 16;
    localparam int GuardBits   = 8;
    localparam int CordicSteps = 22;
    // lane width: sample + guard + growth headroom (gain < 1.65, sign of negated min)
    localparam int LaneWidth   = SampleWidth + GuardBits + 3;
    // angle accumulator: |angle| < 2^(8+FracBits), plus sign and base offset
    localparam int AngWidth    = FracBits + 11;
    localparam int StepWidth   = $clog2(CordicSteps + 1);

    localparam logic [14:0] ThreshReset = 15'd1200;
    localparam logic [8:0]  CorrReset   = 9'd180;
    localparam logic [15:0] ZOffReset   = 16'sd0;
    localparam logic [8:0]  CorrMax     = 9'd360;

    typedef enum logic [1:0] {
        REG_THRESH = 2'd0,
        REG_CORR   = 2'd1,
        REG_ZOFF   = 2'd2
    } t_reg_idx;

    // one CORDIC lane state
    typedef struct packed {
        logic signed [LaneWidth-1:0] x;
        logic signed [LaneWidth-1:0] y;
        logic signed [AngWidth-1:0]  z;
        logic                        done;
    } t_lane;

    function automatic logic signed [AngWidth-1:0] atan_entry(input logic [StepWidth-1:0] i);
        logic signed [AngWidth-1:0] v;
        case (i)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117304;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/acctilt_stage.sv -----
// One CORDIC vectoring micro-rotation over three lanes with a valid bit.
`timescale 1ns / 1ps
module acctilt_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [acctilt_pkg::StepWidth-1:0] i_step,
    input  logic                           i_valid,
    input  acctilt_pkg::t_lane             i_lane [3],
    input  logic [48:0]                    i_side,
    output logic                           o_valid,
    output acctilt_pkg::t_lane             o_lane [3],
    output logic [48:0]                    o_side
);
    import acctilt_pkg::*;

    logic signed [AngWidth-1:0] atan_val;

    logic  r_valid;
    t_lane r_lane [3];
    logic [48:0] r_side;
    t_lane n_lane [3];

    // i_step is tied to a constant, so the table and shifts fold away
    assign atan_val = atan_entry(i_step);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k] = i_lane[k];
            if (!i_lane[k].done && i_lane[k].y == '0) begin
                n_lane[k].done = 1'b1;
            end else if (!i_lane[k].done) begin
                // arithmetic shift equals floor division
                if (!i_lane[k].y[LaneWidth-1]) begin
                    n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> i_step);
                    n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> i_step);
                    n_lane[k].z = i_lane[k].z + atan_val;
                end else begin
                    n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> i_step);
                    n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> i_step);
                    n_lane[k].z = i_lane[k].z - atan_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_side  = r_side;
endmodule

// ----- rtl/core/acctilt_regs.sv -----
// APB register file for threshold, correction and z offset.
`timescale 1ns / 1ps
module acctilt_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [14:0] o_thresh,
    output logic [8:0]  o_corr,
    output logic [15:0] o_zoff
);
    import acctilt_pkg::*;

    logic [14:0] r_thresh;
    logic [8:0]  r_corr;
    logic [15:0] r_zoff;
    logic        wr;

    assign wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ThreshReset;
            r_corr   <= CorrReset;
            r_zoff   <= ZOffReset;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_THRESH: r_thresh <= pwdata[14:0];
                REG_CORR:   r_corr   <= pwdata[8:0];
                REG_ZOFF:   r_zoff   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_THRESH: prdata = {17'd0, r_thresh};
            REG_CORR:   prdata = {23'd0, r_corr};
            REG_ZOFF:   prdata = {16'd0, r_zoff};
            default:    prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign o_thresh = r_thresh;
    assign o_corr   = r_corr;
    assign o_zoff   = r_zoff;
endmodule

// ----- rtl/core/accel_tilt_angles_core.sv -----
// Top level: input gating, 22-stage CORDIC pipeline over three lanes, two finish stages.
// Pipeline: 25 register stages (1 prep, 22 CORDIC, 2 finish); o_valid is driven by the
// last finish register, and the result is taken while o_valid is high.
// Throughput: one sample per cycle; busy is always low, each stage is one micro-rotation.
// Reset: synchronous active-low i_rst_n clears valid bits and loads register defaults.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
`timescale 1ns / 1ps
module accel_tilt_angles_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    output logic        o_valid,
    output logic signed [9:0] o_incline_about_x,
    output logic signed [8:0] o_incline_about_y,
    output logic signed [8:0] o_heading_degrees,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import acctilt_pkg::*;

    localparam int AW = AngWidth;
    localparam int LW = LaneWidth;

    // per-lane special-case codes carried down the side word
    localparam logic [2:0] SpNormal  = 3'd0;
    localparam logic [2:0] SpZero    = 3'd1;
    localparam logic [2:0] SpPos90   = 3'd2;
    localparam logic [2:0] SpNeg90   = 3'd3;
    localparam logic [2:0] SpPos180  = 3'd4;
    localparam logic [2:0] SpNeg180  = 3'd5;

    logic [14:0] thresh;
    logic [8:0]  corr;
    logic [15:0] zoff;

    acctilt_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_thresh(thresh), .o_corr(corr), .o_zoff(zoff)
    );

    assign busy = 1'b0;

    // ---- prep stage: gates, special cases, lane setup
    // side word: gate x/y/h (3), saturated corr (9), per-lane special-case code
    //            3 bits each (9), spare
    t_lane p_lane [3];
    logic [48:0] p_side;
    logic signed [16:0] zc;
    logic [16:0] ax, ay, az;
    logic gx, gy, gz;
    logic [8:0] corr_sat;
    logic signed [15:0] num [3];
    logic signed [15:0] den [3];
    logic [2:0] sp_code [3];

    always_comb begin
        zc = 17'(i_accel_z) + 17'(signed'(zoff));
        ax = i_accel_x[15] ? 17'(-17'(i_accel_x)) : 17'(i_accel_x);
        ay = i_accel_y[15] ? 17'(-17'(i_accel_y)) : 17'(i_accel_y);
        az = zc[16] ? 17'(-zc) : 17'(zc);
        gx = ax > 17'(thresh);
        gy = ay > 17'(thresh);
        gz = az > 17'(thresh);
        corr_sat = (corr > CorrMax) ? CorrMax : corr;
        num[0] = i_accel_y; den[0] = i_accel_z;
        num[1] = i_accel_x; den[1] = i_accel_z;
        num[2] = i_accel_x; den[2] = i_accel_y;
        for (int k = 0; k < 3; k++) begin
            // fold a negative denominator into the right half plane, keep the base
            p_lane[k].z    = '0;
            p_lane[k].done = 1'b0;
            p_lane[k].x    = LW'(den[k]) <<< GuardBits;
            p_lane[k].y    = LW'(num[k]) <<< GuardBits;
            if (num[k] == '0 && den[k] == '0) begin
                sp_code[k] = SpZero; p_lane[k].done = 1'b1;
            end else if (den[k] == '0) begin
                sp_code[k] = num[k][15] ? SpNeg90 : SpPos90; p_lane[k].done = 1'b1;
            end else if (den[k][15]) begin
                sp_code[k] = num[k][15] ? SpNeg180 : SpPos180;
                p_lane[k].x = -(LW'(den[k]) <<< GuardBits);
                p_lane[k].y = -(LW'(num[k]) <<< GuardBits);
            end else begin
                sp_code[k] = SpNormal;
            end
        end
        p_side = {28'd0, sp_code[2], sp_code[1], sp_code[0], corr_sat, gx | gy,
                  gx | gz, gy | gz};
    end

    logic  r_pv;
    t_lane r_plane [3];
    logic [48:0] r_pside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= p_lane;
        r_pside <= p_side;
    end

    // ---- CORDIC chain
    logic  c_valid [CordicSteps+1];
    t_lane c_lane  [CordicSteps+1][3];
    logic [48:0] c_side [CordicSteps+1];

    assign c_valid[0] = r_pv;
    assign c_lane[0]  = r_plane;
    assign c_side[0]  = r_pside;

    for (genvar s = 0; s < CordicSteps; s++) begin : g_step
        acctilt_stage u_stage (
            .i_clk, .i_rst_n, .i_step(StepWidth'(s)),
            .i_valid(c_valid[s]), .i_lane(c_lane[s]), .i_side(c_side[s]),
            .o_valid(c_valid[s+1]), .o_lane(c_lane[s+1]), .o_side(c_side[s+1])
        );
    end

    // ---- finish stage 1: full angles with correction
    logic signed [AW-1:0] ang [3];
    logic [48:0] fs;
    logic signed [AW-1:0] corr_f;
    logic signed [AW-1:0] f_val [3];
    logic [2:0] code;

    always_comb begin
        fs = c_side[CordicSteps];
        corr_f = AW'({fs[11:3], 16'd0});
        for (int k = 0; k < 3; k++) begin
            code = fs[12 + 3*k +: 3];
            unique case (code)
                SpZero:   ang[k] = '0;
                SpPos90:  ang[k] = AW'(90 <<< FracBits);
                SpNeg90:  ang[k] = -AW'(90 <<< FracBits);
                SpPos180: ang[k] = c_lane[CordicSteps][k].z + AW'(180 <<< FracBits);
                SpNeg180: ang[k] = c_lane[CordicSteps][k].z - AW'(180 <<< FracBits);
                default:  ang[k] = c_lane[CordicSteps][k].z;
            endcase
        end
        f_val[0] = -ang[0] - corr_f;
        f_val[1] = -ang[1] + corr_f;
        f_val[2] = ang[2];
    end

    logic r_fv;
    logic signed [AW-1:0] r_fval [3];
    logic [2:0] r_fg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= c_valid[CordicSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fval <= f_val;
        r_fg   <= fs[2:0];
    end

    // ---- finish stage 2: truncate toward zero, wrap, saturate x incline, gate
    logic signed [10:0] whole [3];
    logic signed [AW-1:0] mag;
    logic signed [9:0] n_ix;
    logic signed [8:0] n_iy, n_hd;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag = r_fval[k][AW-1] ? -r_fval[k] : r_fval[k];
            whole[k] = 11'(mag >>> FracBits);
            if (r_fval[k][AW-1]) whole[k] = -whole[k];
            if (whole[k] > 11'sd180) whole[k] = whole[k] - 11'sd360;
        end
        n_ix = (whole[0] < -11'sd512) ? -10'sd512 : whole[0][9:0];
        n_iy = whole[1][8:0];
        n_hd = whole[2][8:0];
        if (!r_fg[0]) n_ix = '0;
        if (!r_fg[1]) n_iy = '0;
        if (!r_fg[2]) n_hd = '0;
    end

    logic r_ov;
    logic signed [9:0] r_ix;
    logic signed [8:0] r_iy, r_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ix <= n_ix;
        r_iy <= n_iy;
        r_hd <= n_hd;
    end

    assign o_valid           = r_ov;
    assign o_incline_about_x = r_ix;
    assign o_incline_about_y = r_iy;
    assign o_heading_degrees = r_hd;
endmodule

// ----- rtl/core/acctilt_checker.sv -----
// Port-level checker for the tilt-angle core, bound to the top level.
`timescale 1ns / 1ps
module acctilt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic pready,
    input logic signed [8:0] o_incline_about_y,
    input logic signed [8:0] o_heading_degrees
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 25))
        else $error("result without request");
    a_range_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_incline_about_y >= -9'sd180 && o_heading_degrees >= -9'sd180))
        else $error("angle out of range");
endmodule

bind accel_tilt_angles_core acctilt_checker u_checker (.*);

// ----- bench/accel_tilt_angles_core_tb.sv -----
// Self-checking testbench for the accelerometer tilt and heading angle core.
`timescale 1ns / 1ps
module accel_tilt_angles_core_tb;
    import acctilt_pkg::*;

    localparam int DrainCycles = 40;
    localparam int StallLimit  = 2000;

    typedef struct {
        logic signed [9:0] incl_x;
        logic signed [8:0] incl_y;
        logic signed [8:0] heading;
    } t_angles;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_accel_x;
    logic signed [15:0] i_accel_y;
    logic signed [15:0] i_accel_z;
    logic               o_valid;
    logic signed [9:0]  o_incline_about_x;
    logic signed [8:0]  o_incline_about_y;
    logic signed [8:0]  o_heading_degrees;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // shadow copy of the configuration registers
    logic [14:0]        gate_thresh;
    logic [8:0]         corr_deg;
    logic signed [15:0] z_cal;

    t_angles angle_q[$];
    int      n_errors;
    int      n_samples;
    int      n_angles;
    int      stall_cnt;
    bit      idle_on;
    bit      sent_now;

    accel_tilt_angles_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .o_valid(o_valid), .o_incline_about_x(o_incline_about_x),
        .o_incline_about_y(o_incline_about_y), .o_heading_degrees(o_heading_degrees),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // atan2 in degrees, 16 fractional bits, vectoring CORDIC
    function automatic longint cordic_deg(longint num, longint den);
        longint atan_lut [22] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                  58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                  229, 115, 57, 29, 14, 7, 4, 2};
        longint base;
        longint cx;
        longint cy;
        longint acc;
        longint nx;
        base = 0;
        acc  = 0;
        if (num == 0 && den == 0) return 0;
        if (den == 0) return (num > 0) ? (longint'(90) <<< 16) : -(longint'(90) <<< 16);
        if (den < 0) begin
            base = (num >= 0) ? (longint'(180) <<< 16) : -(longint'(180) <<< 16);
            num = -num;
            den = -den;
        end
        cx = den <<< 8;
        cy = num <<< 8;
        for (int i = 0; i < 22; i++) begin
            if (cy == 0) break;
            if (cy > 0) begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                acc += atan_lut[i];
            end else begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                acc -= atan_lut[i];
            end
            cx = nx;
        end
        return base + acc;
    endfunction

    // truncate toward zero, then wrap above 180
    function automatic longint whole_deg(longint v);
        longint r;
        r = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
        if (r > 180) r -= 360;
        return r;
    endfunction

    function automatic t_angles tilt_angles(longint ax, longint ay, longint az);
        t_angles res;
        longint  zc;
        longint  th;
        longint  corr;
        longint  v;
        bit      gx;
        bit      gy;
        bit      gz;
        zc   = az + longint'(z_cal);
        th   = longint'(gate_thresh);
        corr = longint'(corr_deg);
        if (corr > 360) corr = 360;
        gx = ((ax < 0) ? -ax : ax) > th;
        gy = ((ay < 0) ? -ay : ay) > th;
        gz = ((zc < 0) ? -zc : zc) > th;
        res = '{default: '0};
        if (gy || gz) begin
            v = whole_deg(-cordic_deg(ay, az) - (corr <<< 16));
            if (v < -512) v = -512;
            res.incl_x = v[9:0];
        end
        if (gx || gz) begin
            v = whole_deg(-cordic_deg(ax, az) + (corr <<< 16));
            res.incl_y = v[8:0];
        end
        if (gx || gy) begin
            v = whole_deg(cordic_deg(ax, ay));
            res.heading = v[8:0];
        end
        return res;
    endfunction

    // check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_angles want;
        sent_now = i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            n_angles++;
            if (angle_q.size() == 0) begin
                $error("unexpected result: x=%0d y=%0d h=%0d", o_incline_about_x,
                       o_incline_about_y, o_heading_degrees);
                n_errors++;
            end else begin
                want = angle_q.pop_front();
                if (o_incline_about_x !== want.incl_x) begin
                    $error("incline_about_x: expected %0d, got %0d", want.incl_x,
                           o_incline_about_x);
                    n_errors++;
                end
                if (o_incline_about_y !== want.incl_y) begin
                    $error("incline_about_y: expected %0d, got %0d", want.incl_y,
                           o_incline_about_y);
                    n_errors++;
                end
                if (o_heading_degrees !== want.heading) begin
                    $error("heading_degrees: expected %0d, got %0d", want.heading,
                           o_heading_degrees);
                    n_errors++;
                end
            end
        end
        if (sent_now || (i_rst_n && o_valid) || psel) stall_cnt = 0;
        else stall_cnt++;
        if (stall_cnt >= StallLimit) begin
            $display("watchdog: no progress for %0d cycles", StallLimit);
            $display("accel_tilt_angles_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
        int gap;
        start     <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        do @(posedge i_clk); while (busy);
        angle_q.push_back(tilt_angles(ax, ay, az));
        n_samples++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the request line low until every pending result is back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (angle_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESH: gate_thresh = val[14:0];
            REG_CORR:   corr_deg    = val[8:0];
            REG_ZOFF:   z_cal       = val[15:0];
            default:    ;
        endcase
    endtask

    task automatic set_config(logic [14:0] th, logic [8:0] corr, logic signed [15:0] zo);
        drain();
        write_reg(REG_THRESH, {17'd0, th});
        write_reg(REG_CORR, {23'd0, corr});
        write_reg(REG_ZOFF, {16'd0, zo});
    endtask

    // random sample shaped toward gate edges, axes and diagonals
    task automatic send_random();
        logic signed [15:0] v [3];
        int                 kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            case (kind)
                0, 1, 2, 3: v[k] = 16'($urandom);
                4, 5:       v[k] = 16'(int'($urandom_range(0, 4000)) - 2000);
                6:          v[k] = ($urandom_range(0, 2) == 0) ? 16'sd0 : 16'($urandom);
                7:          v[k] = (k == 0) ? 16'($urandom) : v[0];
                8:          v[k] = (k == 0) ? 16'($urandom) : -v[k-1];
                default:    v[k] = 16'(int'($urandom_range(0, 64)) - 32);
            endcase
        end
        send_sample(v[0], v[1], v[2]);
    endtask

    task automatic test_directed();
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0, -16'sd5000);
        send_sample(16'sd5000, 16'sd0, 16'sd0);
        send_sample(-16'sd5000, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd5000, 16'sd0);
        send_sample(-16'sd5000, -16'sd5000, 16'sd0);
        send_sample(16'sd3000, 16'sd3000, 16'sd3000);
        send_sample(-16'sd3000, 16'sd3000, -16'sd3000);
        send_sample(16'sd100, -16'sd100, 16'sd100);
        send_sample(16'sd1200, 16'sd1200, -16'sd1200);
        send_sample(16'sd1201, -16'sd1201, 16'sd1201);
        send_sample(-16'sd1, 16'sd1, -16'sd20000);
        send_sample(16'sd20000, -16'sd1, 16'sd1);
        send_sample(16'sd0, -16'sd32768, -16'sd1);
    endtask

    task automatic test_config_sweep();
        set_config(15'd0, 9'd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0, -16'sd1);
        repeat (15) send_random();
        set_config(15'd32767, 9'd360, 16'sd32767);
        send_sample(16'sd0, 16'sd0, -16'sd32768);
        send_sample(16'sd0, 16'sd0, 16'sd1);
        send_sample(16'sd0, 16'sd32767, -16'sd32768);
        repeat (15) send_random();
        set_config(15'd500, 9'd511, -16'sd32768);
        send_sample(16'sd0, 16'sd100, -16'sd32768);
        send_sample(16'sd0, -16'sd100, -16'sd32768);
        repeat (15) send_random();
        set_config(15'd1000, 9'd361, -16'sd300);
        repeat (20) send_random();
        set_config(15'($urandom_range(0, 3000)), 9'($urandom_range(0, 511)), 16'($urandom));
        repeat (20) send_random();
    endtask

    task automatic test_random_idle();
        idle_on = 1'b1;
        set_config(15'd1200, 9'd180, 16'sd0);
        repeat (200) send_random();
        drain();
        repeat (100) send_random();
    endtask

    task automatic test_random_back_to_back();
        idle_on = 1'b0;
        repeat (100) send_random();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_accel_x   = '0;
        i_accel_y   = '0;
        i_accel_z   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        gate_thresh = ThreshReset;
        corr_deg    = CorrReset;
        z_cal       = ZOffReset;
        n_errors    = 0;
        n_samples   = 0;
        n_angles    = 0;
        stall_cnt   = 0;
        idle_on     = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_random_idle();
        test_random_back_to_back();

        drain();
        repeat (DrainCycles) @(posedge i_clk);
        if (angle_q.size() != 0) begin
            $error("%0d expected results never arrived", angle_q.size());
            n_errors++;
        end
        $display("covered %0d samples, %0d results checked, over reset and swept",
                 n_samples, n_angles);
        $display("gate, correction and z offset settings, with and without idle gaps");
        if (n_errors == 0) begin
            $display("accel_tilt_angles_core_tb: done, clean");
        end else begin
            $display("accel_tilt_angles_core_tb: done, errors");
        end
        $finish;
    end

endmodule
